// File: design/frbr_pkg.sv
`default_nettype none

package frbr_pkg;

	localparam int DEF_SLOT_COUNT  = 4;
	localparam int DEF_FRAME_BYTES = 80;

	localparam int ACTION_W    = 2;
	localparam int BYTE_W      = 8;
	localparam int INDEX_W     = 7;
	localparam int LEN_W       = 7;
	localparam int CFG_INDEX_W = 2;

	localparam logic [BYTE_W-1:0] START_RESET  = 8'hAA;
	localparam logic [BYTE_W-1:0] END_RESET    = 8'hFF;
	localparam logic [LEN_W-1:0]  MAXLEN_RESET = 7'd80;

	typedef enum logic [ACTION_W-1:0] {
		ACT_BYTE    = 2'd0,
		ACT_READ    = 2'd1,
		ACT_RELEASE = 2'd2,
		ACT_NOP     = 2'd3
	} action_t;

	typedef enum logic [CFG_INDEX_W-1:0] {
		CFG_START  = 2'd0,
		CFG_END    = 2'd1,
		CFG_MAXLEN = 2'd2,
		CFG_NONE   = 2'd3
	} cfg_reg_t;

	typedef enum logic {
		ST_CLEAR = 1'b0,
		ST_RUN   = 1'b1
	} state_t;

	typedef struct packed {
		logic clear_en;
		logic accept;
	} cmd_t;

	typedef struct packed {
		logic clear_last;
	} status_t;

endpackage

`default_nettype wire

// File: design/frbr_ifs.sv
`default_nettype none

interface frbr_item_if;
	import frbr_pkg::*;
	logic                valid;
	logic                ready;
	logic [ACTION_W-1:0] action;
	logic [BYTE_W-1:0]   rx_byte;
	logic [INDEX_W-1:0]  read_index;

	modport source (output valid, output action, output rx_byte, output read_index,
		input ready);
	modport sink (input valid, input action, input rx_byte, input read_index,
		output ready);
endinterface

interface frbr_result_if #(
	parameter int PEND_W = 3
);
	import frbr_pkg::*;
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] read_data;
	logic [PEND_W-1:0] pending_frames;
	logic              in_frame;
	logic              frame_done;
	logic              frame_dropped;
	logic              overflow;

	modport source (output valid, output read_data, output pending_frames,
		output in_frame, output frame_done, output frame_dropped, output overflow,
		input ready);
	modport sink (input valid, input read_data, input pending_frames,
		input in_frame, input frame_done, input frame_dropped, input overflow,
		output ready);
endinterface

interface frbr_cfg_if;
	import frbr_pkg::*;
	logic                   valid;
	logic                   ready;
	logic [CFG_INDEX_W-1:0] reg_index;
	logic [BYTE_W-1:0]      wdata;

	modport source (output valid, output reg_index, output wdata, input ready);
	modport sink (input valid, input reg_index, input wdata, output ready);
endinterface

`default_nettype wire

// File: design/frbr_ctrl.sv
`default_nettype none

module frbr_ctrl (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               item_valid,
	output logic              item_ready,
	output logic              result_valid,
	input  wire               result_ready,
	output frbr_pkg::cmd_t    cmd,
	input  frbr_pkg::status_t status
);
	import frbr_pkg::*;

	state_t state_q, state_d;
	logic   out_valid_q, out_valid_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			out_valid_q <= out_valid_d;
		end
	end

	always_comb begin
		state_d      = state_q;
		cmd.clear_en = 1'b0;
		item_ready   = 1'b0;
		unique case (state_q)
			ST_CLEAR: begin
				cmd.clear_en = 1'b1;
				if (status.clear_last) begin
					state_d = ST_RUN;
				end
			end
			ST_RUN: begin
				item_ready = !out_valid_q || result_ready;
			end
			default: begin
				state_d = ST_CLEAR;
			end
		endcase
		cmd.accept = item_valid && item_ready;
		if (cmd.accept) begin
			out_valid_d = 1'b1;
		end else if (result_ready) begin
			out_valid_d = 1'b0;
		end else begin
			out_valid_d = out_valid_q;
		end
	end

	assign result_valid = out_valid_q;

	a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CLEAR) |-> !item_ready)
		else $error("item beat taken during the clearing pass");

	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.accept |=> result_valid)
		else $error("accepted beat produced no result");

	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && !result_ready) |=> result_valid)
		else $error("stalled result withdrawn");

endmodule

`default_nettype wire

// File: design/frbr_datapath.sv
`default_nettype none

module frbr_datapath #(
	parameter int SLOT_COUNT  = frbr_pkg::DEF_SLOT_COUNT,
	parameter int FRAME_BYTES = frbr_pkg::DEF_FRAME_BYTES,
	parameter int PEND_W      = $clog2(SLOT_COUNT + 1)
) (
	input  wire                               clk,
	input  wire                               arst_n,
	input  frbr_pkg::cmd_t                    cmd,
	output frbr_pkg::status_t                 status,
	input  wire  [frbr_pkg::ACTION_W-1:0]     item_action,
	input  wire  [frbr_pkg::BYTE_W-1:0]       item_rx_byte,
	input  wire  [frbr_pkg::INDEX_W-1:0]      item_read_index,
	input  wire                               cfg_write,
	input  wire  [frbr_pkg::CFG_INDEX_W-1:0]  cfg_reg_index,
	input  wire  [frbr_pkg::BYTE_W-1:0]       cfg_wdata,
	output logic [frbr_pkg::BYTE_W-1:0]       read_data,
	output logic [PEND_W-1:0]                 pending_frames,
	output logic                              in_frame,
	output logic                              frame_done,
	output logic                              frame_dropped,
	output logic                              overflow
);
	import frbr_pkg::*;

	localparam int DEPTH  = SLOT_COUNT * FRAME_BYTES;
	localparam int AW     = $clog2(DEPTH);
	localparam int SW     = $clog2(SLOT_COUNT);
	localparam int CNT_W  = $clog2(FRAME_BYTES + 1);
	localparam int CMP_W  = (CNT_W > INDEX_W) ? CNT_W : INDEX_W;
	localparam logic [SW-1:0]     LAST_SLOT = SW'(SLOT_COUNT - 1);
	localparam logic [PEND_W-1:0] FULL      = PEND_W'(SLOT_COUNT);
	localparam logic [AW-1:0]     LAST_ADDR = AW'(DEPTH - 1);
	localparam logic [CMP_W-1:0]  FB_CMP    = CMP_W'(FRAME_BYTES);

	logic [BYTE_W-1:0] mem_q [DEPTH];
	logic [BYTE_W-1:0] rd_q;
	logic              rd_sel_q;
	logic [AW-1:0]     clr_q;

	logic [BYTE_W-1:0] start_q, end_q;
	logic [LEN_W-1:0]  maxlen_q;

	logic              recv_q, recv_d;
	logic [CNT_W-1:0]  count_q, count_d;
	logic [SW-1:0]     wslot_q, wslot_d;
	logic [SW-1:0]     rslot_q, rslot_d;
	logic [PEND_W-1:0] wait_q, wait_d;
	logic              done_q, drop_q, ovf_q;
	logic              done_d, drop_d, ovf_d;

	action_t           act;
	logic              start_hit, end_hit, opening, active;
	logic [CNT_W-1:0]  count_cur, count_inc;
	logic [CMP_W-1:0]  limit, maxlen_ext, inc_ext, idx_ext;
	logic              idx_ok, mem_we, rd_en;
	logic [AW-1:0]     waddr, raddr;
	logic [BYTE_W-1:0] wdata;

	always_comb begin
		act        = action_t'(item_action);
		start_hit  = !recv_q && (item_rx_byte == start_q);
		end_hit    = item_rx_byte == end_q;
		ovf_d      = 1'b0;
		opening    = 1'b0;
		if (start_hit) begin
			if (wait_q >= FULL) begin
				ovf_d = 1'b1;
			end else begin
				opening = 1'b1;
			end
		end
		active     = recv_q || opening;
		count_cur  = opening ? '0 : count_q;
		count_inc  = count_cur + 1'b1;
		maxlen_ext = CMP_W'(maxlen_q);
		limit      = (maxlen_ext > FB_CMP) ? FB_CMP : maxlen_ext;
		inc_ext    = CMP_W'(count_inc);
		idx_ext    = CMP_W'(item_read_index);
		idx_ok     = idx_ext < FB_CMP;

		recv_d  = recv_q;
		count_d = count_q;
		wslot_d = wslot_q;
		rslot_d = rslot_q;
		wait_d  = wait_q;
		done_d  = 1'b0;
		drop_d  = 1'b0;
		mem_we  = 1'b0;
		rd_en   = 1'b0;
		unique case (act)
			ACT_BYTE: begin
				if (active) begin
					mem_we = 1'b1;
					if (end_hit) begin
						recv_d  = 1'b0;
						count_d = '0;
						wslot_d = (wslot_q == LAST_SLOT) ? '0 : wslot_q + 1'b1;
						wait_d  = wait_q + 1'b1;
						done_d  = 1'b1;
					end else if (inc_ext >= limit) begin
						recv_d  = 1'b0;
						count_d = '0;
						drop_d  = 1'b1;
					end else begin
						recv_d  = 1'b1;
						count_d = count_inc;
					end
				end
			end
			ACT_READ: begin
				rd_en = idx_ok;
			end
			ACT_RELEASE: begin
				if (wait_q != '0) begin
					wait_d  = wait_q - 1'b1;
					rslot_d = (rslot_q == LAST_SLOT) ? '0 : rslot_q + 1'b1;
				end
			end
			ACT_NOP: begin
			end
			default: begin
			end
		endcase
		if (act != ACT_BYTE) begin
			ovf_d = 1'b0;
		end

		raddr = AW'(rslot_q) * AW'(FRAME_BYTES) + AW'(item_read_index);
		if (cmd.clear_en) begin
			waddr = clr_q;
			wdata = '0;
		end else begin
			waddr = AW'(wslot_q) * AW'(FRAME_BYTES) + AW'(count_cur);
			wdata = item_rx_byte;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.clear_en || (cmd.accept && mem_we)) begin
			mem_q[waddr] <= wdata;
		end
		if (cmd.accept && rd_en) begin
			rd_q <= mem_q[raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q    <= '0;
			start_q  <= START_RESET;
			end_q    <= END_RESET;
			maxlen_q <= MAXLEN_RESET;
			recv_q   <= 1'b0;
			count_q  <= '0;
			wslot_q  <= '0;
			rslot_q  <= '0;
			wait_q   <= '0;
			done_q   <= 1'b0;
			drop_q   <= 1'b0;
			ovf_q    <= 1'b0;
			rd_sel_q <= 1'b0;
		end else begin
			if (cmd.clear_en) begin
				clr_q <= (clr_q == LAST_ADDR) ? '0 : clr_q + 1'b1;
			end
			if (cfg_write) begin
				unique case (cfg_reg_t'(cfg_reg_index))
					CFG_START:  start_q  <= cfg_wdata;
					CFG_END:    end_q    <= cfg_wdata;
					CFG_MAXLEN: maxlen_q <= cfg_wdata[LEN_W-1:0];
					CFG_NONE: begin
					end
					default: begin
					end
				endcase
			end
			if (cmd.accept) begin
				recv_q   <= recv_d;
				count_q  <= count_d;
				wslot_q  <= wslot_d;
				rslot_q  <= rslot_d;
				wait_q   <= wait_d;
				done_q   <= done_d;
				drop_q   <= drop_d;
				ovf_q    <= ovf_d;
				rd_sel_q <= rd_en;
			end
		end
	end

	assign status.clear_last = clr_q == LAST_ADDR;
	assign read_data         = rd_sel_q ? rd_q : '0;
	assign pending_frames    = wait_q;
	assign in_frame          = recv_q;
	assign frame_done        = done_q;
	assign frame_dropped     = drop_q;
	assign overflow          = ovf_q;

	a_wait_bound: assert property (@(posedge clk) disable iff (!arst_n)
		wait_q <= FULL)
		else $error("pending count beyond the number of slots");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		recv_q |-> (CMP_W'(count_q) < FB_CMP))
		else $error("byte count beyond the slot size while receiving");

	a_commit_counts: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.accept && done_d) |=> (wait_q == $past(wait_q) + 1'b1))
		else $error("committed frame not counted");

	a_flags_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({done_q, drop_q, ovf_q}))
		else $error("more than one frame event flagged for one beat");

endmodule

`default_nettype wire

// File: design/framed_byte_receiver_ring_unit.sv
// Channel   Role    Beat carries
// item      sink    action, rx_byte, read_index
// result    source  read_data, pending_frames, in_frame, frame_done,
//                   frame_dropped, overflow
// cfg       sink    reg_index, wdata (always ready)
//
// One item beat is taken per cycle; its result appears in the output register
// on the following cycle. The frame store has one write and one read port, and
// each item uses at most one of them. After reset the store is cleared one byte
// a cycle, all SLOT_COUNT * FRAME_BYTES bytes (320 by default), with no item
// beat taken meanwhile. While a result is stalled no further item beat is taken.
`default_nettype none

module framed_byte_receiver_ring_unit #(
	parameter int SLOT_COUNT  = frbr_pkg::DEF_SLOT_COUNT,
	parameter int FRAME_BYTES = frbr_pkg::DEF_FRAME_BYTES
) (
	input wire            clk,
	input wire            arst_n,
	frbr_item_if.sink     item,
	frbr_result_if.source result,
	frbr_cfg_if.sink      cfg
);
	import frbr_pkg::*;

	localparam int PEND_W = $clog2(SLOT_COUNT + 1);

	cmd_t    cmd;
	status_t status;

	assign cfg.ready = 1'b1;

	frbr_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item.valid),
		.item_ready   (item.ready),
		.result_valid (result.valid),
		.result_ready (result.ready),
		.cmd          (cmd),
		.status       (status)
	);

	frbr_datapath #(
		.SLOT_COUNT  (SLOT_COUNT),
		.FRAME_BYTES (FRAME_BYTES),
		.PEND_W      (PEND_W)
	) u_datapath (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.status          (status),
		.item_action     (item.action),
		.item_rx_byte    (item.rx_byte),
		.item_read_index (item.read_index),
		.cfg_write       (cfg.valid),
		.cfg_reg_index   (cfg.reg_index),
		.cfg_wdata       (cfg.wdata),
		.read_data       (result.read_data),
		.pending_frames  (result.pending_frames),
		.in_frame        (result.in_frame),
		.frame_done      (result.frame_done),
		.frame_dropped   (result.frame_dropped),
		.overflow        (result.overflow)
	);

endmodule

`default_nettype wire
